[hdl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Z-Y-X Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

    // fixed field widths
    localparam int QW          = 16;
    localparam int OUT_W       = 16;
    localparam int THR_W       = 15;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // parameter defaults
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // angle accumulator in 2^-16 degree
    localparam int TAB_LEN     = 24;
    localparam int ANG_W       = 27;
    localparam int ROUND_SHIFT = 9;
    localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ROUND_BIAS    = 27'sd256;
    localparam logic signed [OUT_W-1:0] OUT_LIMIT     = 16'sd23040;

    // register index of the threshold (paddr bit 2)
    localparam logic REG_THRESH = 1'b0;

    // width of the product sums and of the matrix terms
    function automatic int sum_width(input int frac);
        int pw;
        pw = 2 * QW + 1;
        return (pw + 2 > 2 * frac + 2) ? pw + 2 : 2 * frac + 2;
    endfunction

    function automatic int mat_width(input int frac);
        return sum_width(frac) - frac;
    endfunction

    function automatic int used_stages(input int ns);
        return (ns < TAB_LEN) ? ns : TAB_LEN;
    endfunction

    // rounded atan(2^-i) in 2^-16 degree
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front
// Front pipeline: products, matrix terms, squared magnitude, bit-per-stage
// square root and branch selection of the atan2 operands.
// ----------------------------------------------------------------------------
module qte_front #(
    parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF,
    parameter int MW             = qte_pkg::mat_width(qte_pkg::QUAT_FRAC_BITS_DEF)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_fire,
    input  logic signed [qte_pkg::QW-1:0]   quat_x,
    input  logic signed [qte_pkg::QW-1:0]   quat_y,
    input  logic signed [qte_pkg::QW-1:0]   quat_z,
    input  logic signed [qte_pkg::QW-1:0]   quat_w,
    input  logic [qte_pkg::THR_W-1:0]       thresh,
    output logic                            out_vld,
    output logic signed [MW-1:0]            roll_y,
    output logic signed [MW-1:0]            roll_x,
    output logic signed [MW-1:0]            pitch_y,
    output logic signed [MW-1:0]            pitch_x,
    output logic signed [MW-1:0]            yaw_y,
    output logic signed [MW-1:0]            yaw_x,
    output logic                            lock
);
    import qte_pkg::*;

    localparam int PW = 2 * QW + 1;
    localparam int SW = sum_width(QUAT_FRAC_BITS);
    localparam int RW = 2 * MW;
    localparam int CW = 7 * MW;
    localparam logic signed [SW-1:0] ONE2 = SW'(1) <<< (2 * QUAT_FRAC_BITS);

    // stage 1 products
    logic signed [QW:0]   x2, y2, z2;
    logic signed [PW-1:0] xx_reg, xy_reg, xz_reg, yy_reg, yz_reg, zz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic                 v1_reg;

    assign x2 = {quat_x, 1'b0};
    assign y2 = {quat_y, 1'b0};
    assign z2 = {quat_z, 1'b0};

    always_ff @(posedge clk)
    begin
        xx_reg <= PW'(quat_x) * PW'(x2);
        xy_reg <= PW'(quat_x) * PW'(y2);
        xz_reg <= PW'(quat_x) * PW'(z2);
        yy_reg <= PW'(quat_y) * PW'(y2);
        yz_reg <= PW'(quat_y) * PW'(z2);
        zz_reg <= PW'(quat_z) * PW'(z2);
        wx_reg <= PW'(quat_w) * PW'(x2);
        wy_reg <= PW'(quat_w) * PW'(y2);
        wz_reg <= PW'(quat_w) * PW'(z2);
    end

    // stage 2 matrix terms, floor shift taken as a part-select
    logic signed [SW-1:0] d11, d21, d22, d31, d32, d23, d33;
    logic signed [MW-1:0] m11_reg, m21_reg, m22_reg, m31_reg, m32_reg, m23_reg, m33_reg;
    logic                 v2_reg;

    always_comb
    begin
        d11 = ONE2 - (SW'(yy_reg) + SW'(zz_reg));
        d21 = SW'(xy_reg) + SW'(wz_reg);
        d22 = ONE2 - (SW'(xx_reg) + SW'(zz_reg));
        d31 = SW'(xz_reg) - SW'(wy_reg);
        d32 = SW'(yz_reg) + SW'(wx_reg);
        d23 = SW'(yz_reg) - SW'(wx_reg);
        d33 = ONE2 - (SW'(xx_reg) + SW'(yy_reg));
    end

    always_ff @(posedge clk)
    begin
        m11_reg <= d11[SW-1:QUAT_FRAC_BITS];
        m21_reg <= d21[SW-1:QUAT_FRAC_BITS];
        m22_reg <= d22[SW-1:QUAT_FRAC_BITS];
        m31_reg <= d31[SW-1:QUAT_FRAC_BITS];
        m32_reg <= d32[SW-1:QUAT_FRAC_BITS];
        m23_reg <= d23[SW-1:QUAT_FRAC_BITS];
        m33_reg <= d33[SW-1:QUAT_FRAC_BITS];
    end

    // stage 3 squares of the magnitudes
    logic [MW-1:0] a11, a21;
    logic [RW-1:0] sq11_reg, sq21_reg;
    logic [CW-1:0] c3_reg;
    logic          v3_reg;

    assign a11 = m11_reg[MW-1] ? MW'(-m11_reg) : MW'(m11_reg);
    assign a21 = m21_reg[MW-1] ? MW'(-m21_reg) : MW'(m21_reg);

    always_ff @(posedge clk)
    begin
        sq11_reg <= RW'(a11) * RW'(a21 & '0 | a11);
        sq21_reg <= RW'(a21) * RW'(a21);
        c3_reg   <= {m11_reg, m21_reg, m22_reg, m23_reg, m31_reg, m32_reg, m33_reg};
    end

    // stage 4 sum, then square root one result bit per stage
    logic [RW-1:0]   rad_s  [0:MW];
    logic [MW+1:0]   rem_s  [0:MW];
    logic [MW-1:0]   root_s [0:MW];
    logic [CW-1:0]   car_s  [0:MW];
    logic            vs_s   [0:MW];

    always_ff @(posedge clk)
    begin
        rad_s[0]  <= sq11_reg + sq21_reg;
        rem_s[0]  <= '0;
        root_s[0] <= '0;
        car_s[0]  <= c3_reg;
    end

    for (genvar k = 0; k < MW; k++)
    begin : g_sqrt
        logic [MW+1:0] cur;
        logic [MW+1:0] trial;

        assign cur   = {rem_s[k][MW-1:0], rad_s[k][RW-1:RW-2]};
        assign trial = {root_s[k], 2'b01};

        always_ff @(posedge clk)
        begin
            rad_s[k+1] <= rad_s[k] << 2;
            car_s[k+1] <= car_s[k];
            if (cur >= trial)
            begin
                rem_s[k+1]  <= cur - trial;
                root_s[k+1] <= {root_s[k][MW-2:0], 1'b1};
            end
            else
            begin
                rem_s[k+1]  <= cur;
                root_s[k+1] <= {root_s[k][MW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_s[k+1] <= 1'b0;
            else
                vs_s[k+1] <= vs_s[k];
        end
    end

    // branch selection
    logic signed [MW-1:0] c11, c21, c22, c23, c31, c32, c33;
    logic [MW-1:0]        cy;
    logic                 normal;

    assign {c11, c21, c22, c23, c31, c32, c33} = car_s[MW];
    assign cy     = root_s[MW];
    assign normal = cy > MW'(thresh);

    always_ff @(posedge clk)
    begin
        roll_y  <= normal ? c32 : MW'(-c23);
        roll_x  <= normal ? c33 : c22;
        pitch_y <= MW'(-c31);
        pitch_x <= cy;
        yaw_y   <= normal ? c21 : '0;
        yaw_x   <= normal ? c11 : '0;
        lock    <= !normal;
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vs_s[0] <= 1'b0;
            out_vld <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_fire;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vs_s[0] <= v3_reg;
            out_vld <= vs_s[MW];
        end
    end

endmodule

[hdl/qte_fifo.sv]
// ----------------------------------------------------------------------------
// qte_fifo
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module qte_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty,
    output logic         full
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] mem_reg [0:DEPTH-1];
    logic [AW:0]  wp_reg, rp_reg;

    assign dout  = mem_reg[rp_reg[AW-1:0]];
    assign empty = wp_reg == rp_reg;
    assign full  = (wp_reg[AW] != rp_reg[AW]) && (wp_reg[AW-1:0] == rp_reg[AW-1:0]);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg[AW-1:0]] <= din;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
        end
    end

endmodule

[hdl/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring atan2 lane: quadrant fold, one stage per iteration,
// rounding and clamp to 1/128 degree.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int MW = qte_pkg::mat_width(qte_pkg::QUAT_FRAC_BITS_DEF),
    parameter int NS = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [MW-1:0]               y_in,
    input  logic signed [MW-1:0]               x_in,
    output logic signed [qte_pkg::OUT_W-1:0]   angle
);
    import qte_pkg::*;

    localparam int CW = MW + 3;
    localparam int RW = ANG_W - ROUND_SHIFT;

    logic signed [CW-1:0]    x_s [0:NS];
    logic signed [CW-1:0]    y_s [0:NS];
    logic signed [ANG_W-1:0] z_s [0:NS];
    logic                    hold_s [0:NS];

    // quadrant fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hold_s[0] <= y_in == '0;
            if (y_in == '0)
            begin
                x_s[0] <= CW'(x_in);
                y_s[0] <= CW'(y_in);
                z_s[0] <= x_in[MW-1] ? ANG_HALF_TURN : '0;
            end
            else if (x_in[MW-1])
            begin
                x_s[0] <= -CW'(x_in);
                y_s[0] <= -CW'(y_in);
                z_s[0] <= y_in[MW-1] ? -ANG_HALF_TURN : ANG_HALF_TURN;
            end
            else
            begin
                x_s[0] <= CW'(x_in);
                y_s[0] <= CW'(y_in);
                z_s[0] <= '0;
            end
        end
    end

    // micro-rotations
    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        logic signed [CW-1:0]    dx, dy;
        logic signed [ANG_W-1:0] da;

        assign dx = y_s[k] >>> k;
        assign dy = x_s[k] >>> k;
        assign da = atan_entry(5'(k));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hold_s[k+1] <= hold_s[k];
                if (hold_s[k])
                begin
                    x_s[k+1] <= x_s[k];
                    y_s[k+1] <= y_s[k];
                    z_s[k+1] <= z_s[k];
                end
                else if (y_s[k] > 0)
                begin
                    x_s[k+1] <= x_s[k] + dx;
                    y_s[k+1] <= y_s[k] - dy;
                    z_s[k+1] <= z_s[k] + da;
                end
                else
                begin
                    x_s[k+1] <= x_s[k] - dx;
                    y_s[k+1] <= y_s[k] + dy;
                    z_s[k+1] <= z_s[k] - da;
                end
            end
        end
    end

    // round and clamp
    logic signed [ANG_W-1:0] zr;
    logic signed [RW-1:0]    r;

    assign zr = z_s[NS] + ROUND_BIAS;
    assign r  = zr[ANG_W-1:ROUND_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r > RW'(OUT_LIMIT))
                angle <= OUT_LIMIT;
            else if (r < -RW'(OUT_LIMIT))
                angle <= -OUT_LIMIT;
            else
                angle <= r[OUT_W-1:0];
        end
    end

endmodule

[hdl/quaternion_to_euler_zyx_unit.sv]
// MW is 21 matrix-term bits at defaults, and the square root resolves one
//   result bit per stage.
// Throughput: one item per cycle while in_stall is low; the front runs free and a credit counter
//   against the queue depth holds in_stall, the back stalls as a whole.
// Reset: rst_n clears valids, queue pointers, credits and the threshold (0).
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_unit
// Unit quaternion to roll, pitch and yaw in 1/128 degree with gimbal lock flag.
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx_unit #(
    parameter int CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF,
    parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qte_pkg::APB_AW-1:0]         paddr,
    input  logic [qte_pkg::APB_DW-1:0]         pwdata,
    output logic [qte_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [qte_pkg::QW-1:0]      quat_x,
    input  logic signed [qte_pkg::QW-1:0]      quat_y,
    input  logic signed [qte_pkg::QW-1:0]      quat_z,
    input  logic signed [qte_pkg::QW-1:0]      quat_w,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [qte_pkg::OUT_W-1:0]   roll_deg,
    output logic signed [qte_pkg::OUT_W-1:0]   pitch_deg,
    output logic signed [qte_pkg::OUT_W-1:0]   yaw_deg,
    output logic                               gimbal_lock
);
    import qte_pkg::*;

    localparam int MW        = mat_width(QUAT_FRAC_BITS);
    localparam int NS        = used_stages(CORDIC_STAGES);
    localparam int FRONT_LAT = MW + 5;
    localparam int DEPTH     = 2 ** $clog2(FRONT_LAT + 2);
    localparam int NB        = NS + 2;
    localparam int FW        = 6 * MW + 1;
    localparam int CNTW      = $clog2(DEPTH) + 1;

    // configuration register
    logic [THR_W-1:0] thresh_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESH);
    assign prdata = (paddr[2] == REG_THRESH) ? APB_DW'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= '0;
        else if (cfg_wr)
            thresh_reg <= pwdata[THR_W-1:0];
    end

    // credits: items accepted and not yet taken from the queue
    logic            in_fire;
    logic            pop;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    assign in_stall = cnt_reg >= CNTW'(DEPTH);
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_fire && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!in_fire && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // front
    logic                 f_vld, f_lock;
    logic signed [MW-1:0] f_ry, f_rx, f_py, f_px, f_yy, f_yx;

    qte_front #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .MW             (MW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .quat_w  (quat_w),
        .thresh  (thresh_reg),
        .out_vld (f_vld),
        .roll_y  (f_ry),
        .roll_x  (f_rx),
        .pitch_y (f_py),
        .pitch_x (f_px),
        .yaw_y   (f_yy),
        .yaw_x   (f_yx),
        .lock    (f_lock)
    );

    // queue
    logic [FW-1:0]        q_dout;
    logic                 q_empty, q_full;
    logic signed [MW-1:0] b_ry, b_rx, b_py, b_px, b_yy, b_yx;
    logic                 b_lock;

    qte_fifo #(
        .W     (FW),
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_vld),
        .din   ({f_ry, f_rx, f_py, f_px, f_yy, f_yx, f_lock}),
        .pop   (pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    assign {b_ry, b_rx, b_py, b_px, b_yy, b_yx, b_lock} = q_dout;

    // back: whole pipeline holds while the result waits
    logic adv;
    logic bv_reg   [0:NB-1];
    logic lock_reg [0:NB-1];

    assign adv = !(out_valid && out_stall);
    assign pop = adv && !q_empty;

    qte_cordic #(.MW(MW), .NS(NS)) u_roll (
        .clk (clk), .en (adv), .y_in (b_ry), .x_in (b_rx), .angle (roll_deg)
    );

    qte_cordic #(.MW(MW), .NS(NS)) u_pitch (
        .clk (clk), .en (adv), .y_in (b_py), .x_in (b_px), .angle (pitch_deg)
    );

    qte_cordic #(.MW(MW), .NS(NS)) u_yaw (
        .clk (clk), .en (adv), .y_in (b_yy), .x_in (b_yx), .angle (yaw_deg)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lock_reg[0] <= b_lock;
            for (int i = 1; i < NB; i++)
                lock_reg[i] <= lock_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
                bv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg[0] <= pop;
            for (int i = 1; i < NB; i++)
                bv_reg[i] <= bv_reg[i-1];
        end
    end

    assign out_valid   = bv_reg[NB-1];
    assign gimbal_lock = lock_reg[NB-1];

    // checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(DEPTH))
        else $error("credit count above queue depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld |-> !q_full)
        else $error("push into full queue");

    a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gimbal_lock) |-> (yaw_deg == '0))
        else $error("yaw not zero in gimbal lock");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("pop without credit");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives quaternion items with random gaps into the euler angle unit,
// predicts roll, pitch, yaw and gimbal lock per item, and compares each
// result item in order while the threshold register steps through values.
// ----------------------------------------------------------------------------

class euler_scoreboard;
    logic [63:0] pending[$];
    int          mismatches;
    int          checked;

    function void note_item(logic [63:0] angles);
        pending.push_back(angles);
    endfunction

    function void check_item(logic [15:0] roll, logic [15:0] pitch,
                             logic [15:0] yaw, logic lock);
        logic [63:0] exp_angles;
        if (pending.size() == 0)
        begin
            $error("result item with no expectation");
            mismatches++;
            return;
        end
        exp_angles = pending.pop_front();
        checked++;
        if (exp_angles[63:48] !== roll)
        begin
            $error("roll_deg expected %0d actual %0d",
                   $signed(exp_angles[63:48]), $signed(roll));
            mismatches++;
        end
        if (exp_angles[47:32] !== pitch)
        begin
            $error("pitch_deg expected %0d actual %0d",
                   $signed(exp_angles[47:32]), $signed(pitch));
            mismatches++;
        end
        if (exp_angles[31:16] !== yaw)
        begin
            $error("yaw_deg expected %0d actual %0d",
                   $signed(exp_angles[31:16]), $signed(yaw));
            mismatches++;
        end
        if (exp_angles[0] !== lock)
        begin
            $error("gimbal_lock expected %0b actual %0b", exp_angles[0], lock);
            mismatches++;
        end
    endfunction
endclass

module tb_top;
    import qte_pkg::*;

    localparam int STAGES   = 16;
    localparam int FRAC     = 14;
    localparam int LATENCY  = 44;
    localparam longint MAX_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] roll_deg, pitch_deg, yaw_deg;
    logic gimbal_lock;

    logic [14:0] thresh_reg = '0;
    longint cycle_count = 0;
    int sent_items = 0;
    int lock_items = 0;
    euler_scoreboard board;

    quaternion_to_euler_zyx_unit #(.CORDIC_STAGES(STAGES), .QUAT_FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .quat_w(quat_w), .out_valid(out_valid), .out_stall(out_stall),
        .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
        .gimbal_lock(gimbal_lock)
    );

    always #5 clk = ~clk;

    // floor shift, arithmetic
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (y == 0)
            return (x < 0) ? longint'(ANG_HALF_TURN) : 0;
        if (x < 0)
        begin
            z = (y > 0) ? longint'(ANG_HALF_TURN) : -longint'(ANG_HALF_TURN);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < TAB_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_entry(i[4:0]));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_entry(i[4:0]));
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] to_out_units(longint z);
        longint r;
        r = (z + 256) >>> ROUND_SHIFT;
        if (r > 23040)
            r = 23040;
        if (r < -23040)
            r = -23040;
        return r[15:0];
    endfunction

    // expected angles packed as roll, pitch, yaw, flag in bit 0
    function automatic logic [63:0] euler_angles(longint qx, longint qy, longint qz,
                                                 longint qw, logic [14:0] thr);
        longint one2, m11, m21, m22, m31, m32, m23, m33, cy, roll, pitch, yaw;
        logic lock;
        one2 = 64'sd1 <<< (2 * FRAC);
        m11 = floor_shift(one2 - (qy * 2 * qy + qz * 2 * qz), FRAC);
        m21 = floor_shift(qx * 2 * qy + qw * 2 * qz, FRAC);
        m22 = floor_shift(one2 - (qx * 2 * qx + qz * 2 * qz), FRAC);
        m31 = floor_shift(qx * 2 * qz - qw * 2 * qy, FRAC);
        m32 = floor_shift(qy * 2 * qz + qw * 2 * qx, FRAC);
        m23 = floor_shift(qy * 2 * qz - qw * 2 * qx, FRAC);
        m33 = floor_shift(one2 - (qx * 2 * qx + qy * 2 * qy), FRAC);
        cy = int_sqrt(m11 * m11 + m21 * m21);
        pitch = vector_angle(-m31, cy);
        if (cy > longint'(thr))
        begin
            roll = vector_angle(m32, m33);
            yaw = vector_angle(m21, m11);
            lock = 1'b0;
        end
        else
        begin
            roll = vector_angle(-m23, m22);
            yaw = 0;
            lock = 1'b1;
        end
        return {to_out_units(roll), to_out_units(pitch), to_out_units(yaw), 15'd0, lock};
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiving side, random wait before each result item once 300 items are sent
    initial
    begin
        int wait_cycles;
        board = new();
        forever
        begin
            if (sent_items < 300)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 13);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && rst_n));
            board.check_item(roll_deg, pitch_deg, yaw_deg, gimbal_lock);
            if (gimbal_lock)
                lock_items++;
        end
    end

    task automatic write_threshold(logic [14:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_THRESH, 2'b00};
        pwdata <= {17'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thresh_reg = value;
    endtask

    // valid stays high into the next item when there is no gap
    task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [15:0] w, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        quat_w <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(euler_angles($signed(x), $signed(y), $signed(z), $signed(w),
                                     thresh_reg));
        sent_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending.size() != 0 && cycle_count < MAX_CYCLES)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // random quaternion, components mostly within half of unit magnitude
    task automatic send_random(int gap);
        logic [15:0] c[4];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++)
        begin
            if (mode < 6)
                c[k] = 16'($signed($urandom_range(0, 16384)) - 8192);
            else if (mode < 8)
                c[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
            else
                c[k] = 16'($urandom);
        end
        if (mode == 5)
        begin
            // near gimbal lock: pitch close to -90 degrees
            c[0] = 16'(11585 + $signed($urandom_range(0, 64)) - 32);
            c[2] = c[0];
            c[1] = 16'($signed($urandom_range(0, 64)) - 32);
            c[3] = c[1];
        end
        send_quat(c[0], c[1], c[2], c[3], gap);
    endtask

    function automatic int draw_gap();
        return (sent_items % 200 < 40) ? 0 : $urandom_range(0, 13);
    endfunction

    initial
    begin
        logic [14:0] thr_list[5];
        thr_list = '{15'd0, 15'd16384, 15'd200, 15'd4000, 15'd32767};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, axes, extremes, gimbal lock, zero and signs
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 2);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 0);
        send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585, 0);
        send_quat(16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585, 3);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 0);
        send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
        send_quat(16'sd0, 16'sd0, 16'sd11585, -16'sd11585, 0);
        send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 0);
        drain_results();
        write_threshold(15'd16384);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send_quat(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 0);
        drain_results();

        // random phases across threshold settings
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thr_list[p]);
            for (int n = 0; n < 186; n++)
                send_random(draw_gap());
            drain_results();
        end
        write_threshold(15'($urandom_range(0, 16384)));
        for (int n = 0; n < 20; n++)
            send_random(draw_gap());
        drain_results();

        if (board.pending.size() != 0)
        begin
            $error("%0d expected result items never arrived", board.pending.size());
            board.mismatches++;
        end
        $display("covered %0d quaternion items, %0d result items checked, %0d in gimbal lock",
                 sent_items, board.checked, lock_items);
        $display("threshold swept over zero, one, mid values and full register range");
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_fifo.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_zyx_unit.sv
verif/tb_top.sv
